/* sv/csc_pkg.sv */
// Shared constants, types and arctangent table for the CORDIC sine/cosine unit.
`default_nettype none

package csc_pkg;

   localparam int unsigned ATAN_DEPTH = 16;
   localparam int unsigned ATAN_WIDTH = 14;
   localparam int unsigned ANGLE_WIDTH = 16;
   localparam int unsigned OUT_WIDTH = 16;
   localparam int unsigned ITER_WIDTH = 5;
   localparam int unsigned INIT_X_WIDTH = 15;
   localparam int unsigned CSR_DATA_WIDTH = 15;

   // Register indexes on the configuration port.
   localparam logic CSR_ITERATIONS = 1'b0;
   localparam logic CSR_INITIAL_X = 1'b1;

   localparam logic [ITER_WIDTH-1:0] ITERATIONS_RESET = 5'd16;
   localparam logic [INIT_X_WIDTH-1:0] INITIAL_X_RESET = 15'd19432;

   // floor(270 * atan(2^-i)) in degrees, one entry per pass.
   localparam logic [ATAN_WIDTH-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
      14'd12150, 14'd7172, 14'd3789, 14'd1923, 14'd965, 14'd483, 14'd241, 14'd120,
      14'd60, 14'd30, 14'd15, 14'd7, 14'd3, 14'd1, 14'd0, 14'd0
   };

   typedef struct packed {
      logic valid;
      logic active;
   } csc_ctl_type;

endpackage : csc_pkg

`default_nettype wire

/* sv/cordic_sin_cos_fixed_unit.sv */
// Top level of the pipelined rotation-mode CORDIC sine/cosine unit.
`default_nettype none

// Takes one angle (degrees times 270, signed 16 bits) per clock and returns its cosine
// and sine times 32000 after one input register, one register stage per CORDIC pass
// and one output register. Passes beyond the configured count carry the vector
// through unchanged. busy is never raised, and rsp_valid marks each result
// for a single cycle. The receiver cannot stall, so it must take every
// result beat as it comes.
// Write the configuration registers only while no angle is in flight.
module cordic_sin_cos_fixed_unit #(
   parameter int unsigned ITERATIONS_MAX = 16,
   parameter int unsigned DATA_WIDTH = 16
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      start,
   output logic                                     busy,
   input  wire  signed [csc_pkg::ANGLE_WIDTH-1:0]   req_angle,
   output logic                                     rsp_valid,
   output logic signed [csc_pkg::OUT_WIDTH-1:0]     rsp_cosine,
   output logic signed [csc_pkg::OUT_WIDTH-1:0]     rsp_sine,
   input  wire                                      csr_we,
   input  wire                                      csr_index,
   input  wire         [csc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import csc_pkg::*;

   localparam logic [ITER_WIDTH-1:0] PASS_LIMIT = ITER_WIDTH'(ITERATIONS_MAX);

   logic [ITER_WIDTH-1:0]   iterations_ff;
   logic [INIT_X_WIDTH-1:0] initial_x_ff;
   logic [ITER_WIDTH-1:0]   passes;

   logic                          in_valid_ff;
   logic signed [DATA_WIDTH-1:0]  in_x_ff;
   logic signed [ANGLE_WIDTH-1:0] in_target_ff;

   logic                          valid_p  [ITERATIONS_MAX+1];
   logic signed [DATA_WIDTH-1:0]  x_p      [ITERATIONS_MAX+1];
   logic signed [DATA_WIDTH-1:0]  y_p      [ITERATIONS_MAX+1];
   logic signed [DATA_WIDTH-1:0]  acc_p    [ITERATIONS_MAX+1];
   logic signed [ANGLE_WIDTH-1:0] target_p [ITERATIONS_MAX+1];

   logic                          out_valid_ff;
   logic signed [OUT_WIDTH-1:0]   out_cos_ff, out_cos_in;
   logic signed [OUT_WIDTH-1:0]   out_sin_ff, out_sin_in;
   logic signed [31:0]            x_wide;
   logic signed [31:0]            y_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         iterations_ff <= ITERATIONS_RESET;
         initial_x_ff <= INITIAL_X_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ITERATIONS: iterations_ff <= csr_wdata[ITER_WIDTH-1:0];
            CSR_INITIAL_X:  initial_x_ff <= csr_wdata[INIT_X_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign passes = (iterations_ff > PASS_LIMIT) ? PASS_LIMIT : iterations_ff;
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_x_ff <= DATA_WIDTH'({17'd0, initial_x_ff});
      in_target_ff <= req_angle;
   end

   assign valid_p[0] = in_valid_ff;
   assign x_p[0] = in_x_ff;
   assign y_p[0] = '0;
   assign acc_p[0] = '0;
   assign target_p[0] = in_target_ff;

   for (genvar s = 0; s < ITERATIONS_MAX; s++) begin : g_pass
      csc_ctl_type ctl;

      assign ctl.valid = valid_p[s];
      assign ctl.active = (ITER_WIDTH'(s) < passes);

      csc_stage #(
         .DATA_WIDTH (DATA_WIDTH),
         .STAGE      (s)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .ctl_i    (ctl),
         .x_i      (x_p[s]),
         .y_i      (y_p[s]),
         .acc_i    (acc_p[s]),
         .target_i (target_p[s]),
         .valid_o  (valid_p[s+1]),
         .x_o      (x_p[s+1]),
         .y_o      (y_p[s+1]),
         .acc_o    (acc_p[s+1]),
         .target_o (target_p[s+1])
      );
   end

   // Narrow data widths sign-extend into the 16-bit results.
   always_comb begin
      x_wide = 32'(x_p[ITERATIONS_MAX]);
      y_wide = 32'(y_p[ITERATIONS_MAX]);
      out_cos_in = x_wide[OUT_WIDTH-1:0];
      out_sin_in = y_wide[OUT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_p[ITERATIONS_MAX];
      end
   end

   always_ff @(posedge clock) begin
      out_cos_ff <= out_cos_in;
      out_sin_ff <= out_sin_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_cosine = out_cos_ff;
   assign rsp_sine = out_sin_ff;

   a_start_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(ITERATIONS_MAX + 2) rsp_valid)
      else $error("accepted angle produced no result beat");

   a_no_start_no_result: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##(ITERATIONS_MAX + 2) !rsp_valid)
      else $error("result beat without a matching start");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe raised right after reset");

endmodule : cordic_sin_cos_fixed_unit

`default_nettype wire

/* sv/csc_stage.sv */
// One registered CORDIC rotation pass with a fixed shift amount.
`default_nettype none

module csc_stage #(
   parameter int unsigned DATA_WIDTH = 16,
   parameter int unsigned STAGE = 0
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  csc_pkg::csc_ctl_type                ctl_i,
   input  wire  signed [DATA_WIDTH-1:0]        x_i,
   input  wire  signed [DATA_WIDTH-1:0]        y_i,
   input  wire  signed [DATA_WIDTH-1:0]        acc_i,
   input  wire  signed [csc_pkg::ANGLE_WIDTH-1:0] target_i,
   output logic                                valid_o,
   output logic signed [DATA_WIDTH-1:0]        x_o,
   output logic signed [DATA_WIDTH-1:0]        y_o,
   output logic signed [DATA_WIDTH-1:0]        acc_o,
   output logic signed [csc_pkg::ANGLE_WIDTH-1:0] target_o
);
   import csc_pkg::*;

   localparam int unsigned CMP_WIDTH = (DATA_WIDTH > ANGLE_WIDTH) ? DATA_WIDTH : ANGLE_WIDTH;
   localparam int unsigned ROM_INDEX = STAGE % ATAN_DEPTH;

   logic                         valid_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, x_in;
   logic signed [DATA_WIDTH-1:0] y_ff, y_in;
   logic signed [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic signed [ANGLE_WIDTH-1:0] target_ff;

   logic signed [CMP_WIDTH-1:0]  acc_ext;
   logic signed [CMP_WIDTH-1:0]  target_ext;
   logic        [DATA_WIDTH-1:0] theta;
   logic signed [DATA_WIDTH-1:0] x_shift;
   logic signed [DATA_WIDTH-1:0] y_shift;

   always_comb begin
      acc_ext = CMP_WIDTH'(acc_i);
      target_ext = CMP_WIDTH'(target_i);
      // The table entry wraps into the angle register width like the sum does.
      theta = DATA_WIDTH'({18'd0, ATAN_TABLE[ROM_INDEX]});
      x_shift = x_i >>> STAGE;
      y_shift = y_i >>> STAGE;
      x_in = x_i;
      y_in = y_i;
      acc_in = acc_i;
      if (ctl_i.active) begin
         if (acc_ext < target_ext) begin
            x_in = x_i - y_shift;
            y_in = y_i + x_shift;
            acc_in = acc_i + $signed(theta);
         end else begin
            x_in = x_i + y_shift;
            y_in = y_i - x_shift;
            acc_in = acc_i - $signed(theta);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      target_ff <= target_i;
   end

   assign valid_o = valid_ff;
   assign x_o = x_ff;
   assign y_o = y_ff;
   assign acc_o = acc_ff;
   assign target_o = target_ff;

endmodule : csc_stage

`default_nettype wire
